### rtl/falu_pkg.sv
`timescale 1ns / 1ps

package falu_pkg;

	// Command codes
	localparam logic [4:0] CMD_FROM_FRAC = 5'd0;
	localparam logic [4:0] CMD_FROM_INT  = 5'd1;
	localparam logic [4:0] CMD_ADD       = 5'd2;
	localparam logic [4:0] CMD_ADD_INT   = 5'd3;
	localparam logic [4:0] CMD_SUB       = 5'd4;
	localparam logic [4:0] CMD_SUB_INT   = 5'd5;
	localparam logic [4:0] CMD_MUL       = 5'd6;
	localparam logic [4:0] CMD_MUL_INT   = 5'd7;
	localparam logic [4:0] CMD_DIV       = 5'd8;
	localparam logic [4:0] CMD_DIV_INT   = 5'd9;
	localparam logic [4:0] CMD_MIN       = 5'd10;
	localparam logic [4:0] CMD_MAX       = 5'd11;
	localparam logic [4:0] CMD_GT        = 5'd12;
	localparam logic [4:0] CMD_GT_INT    = 5'd13;
	localparam logic [4:0] CMD_LT        = 5'd14;
	localparam logic [4:0] CMD_LE        = 5'd15;
	localparam logic [4:0] CMD_LT_INT    = 5'd16;
	localparam logic [4:0] CMD_LE_INT    = 5'd17;
	localparam logic [4:0] CMD_CEIL      = 5'd18;
	localparam logic [4:0] CMD_FLOOR     = 5'd19;
	localparam logic [4:0] CMD_ROUND     = 5'd20;
	localparam logic [4:0] CMD_EQ        = 5'd21;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVF   = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	localparam int FracBits = 32;
	localparam int DivSteps = 96;
	localparam logic [63:0] HalfLsb = 64'h0000_0000_8000_0000;

	// Result fields that ride along the divider chain
	typedef struct packed {
		logic [4:0]  cmd;
		logic [63:0] res;
		logic        cmp;
		logic [1:0]  st;
	} side_t;

	// Restoring divider state: remainder, dividend bits shifting out while
	// quotient bits shift in, divisor
	typedef struct packed {
		logic [63:0] rem;
		logic [95:0] bits;
		logic [63:0] dvs;
	} div_t;

	// Partial products of the Q32.32 multiply
	typedef struct packed {
		logic [63:0] hh;
		logic [63:0] hl;
		logic [63:0] lh;
		logic [63:0] ll;
	} prod_t;

endpackage

### rtl/falu_req_if.sv
`timescale 1ns / 1ps

interface falu_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  command;
	logic [63:0] lhs_value;
	logic [63:0] rhs_value;

	modport source (output valid, command, lhs_value, rhs_value, input ready);
	modport sink (input valid, command, lhs_value, rhs_value, output ready);
endinterface

### rtl/falu_rsp_if.sv
`timescale 1ns / 1ps

interface falu_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic        compare_true;
	logic [1:0]  status;

	modport source (output valid, result_value, compare_true, status, input ready);
	modport sink (input valid, result_value, compare_true, status, output ready);
endinterface

### rtl/falu_front.sv
`timescale 1ns / 1ps

module falu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld,
	input  logic [4:0]         command,
	input  logic [63:0]        lhs_value,
	input  logic [63:0]        rhs_value,
	output logic               vld_s1,
	output falu_pkg::side_t    side_s1,
	output falu_pkg::div_t     div_s1,
	output falu_pkg::prod_t    prod_s1
);

	logic [63:0]     bint;
	logic [63:0]     mb;
	logic [64:0]     sum_ab;
	logic [64:0]     sum_ai;
	logic [64:0]     sum_rd;
	logic            frac_nz;
	falu_pkg::side_t side_d;
	falu_pkg::div_t  div_d;
	falu_pkg::prod_t prod_d;

	assign bint    = {rhs_value[31:0], 32'b0};
	assign mb      = (command == falu_pkg::CMD_MUL_INT) ? bint : rhs_value;
	assign sum_ab  = {1'b0, lhs_value} + {1'b0, rhs_value};
	assign sum_ai  = {1'b0, lhs_value} + {1'b0, bint};
	assign sum_rd  = {1'b0, lhs_value} + {1'b0, falu_pkg::HalfLsb};
	assign frac_nz = lhs_value[31:0] != 32'b0;

	always_comb begin
		prod_d.hh = {32'b0, lhs_value[63:32]} * {32'b0, mb[63:32]};
		prod_d.hl = {32'b0, lhs_value[63:32]} * {32'b0, mb[31:0]};
		prod_d.lh = {32'b0, lhs_value[31:0]} * {32'b0, mb[63:32]};
		prod_d.ll = {32'b0, lhs_value[31:0]} * {32'b0, mb[31:0]};
	end

	always_comb begin
		div_d.rem = 64'b0;
		case (command)
			falu_pkg::CMD_FROM_FRAC: begin
				div_d.bits = {lhs_value[31:0], 64'b0};
				div_d.dvs  = bint;
			end
			falu_pkg::CMD_DIV: begin
				div_d.bits = {lhs_value, 32'b0};
				div_d.dvs  = rhs_value;
			end
			default: begin
				div_d.bits = {lhs_value, 32'b0};
				div_d.dvs  = bint;
			end
		endcase
	end

	always_comb begin
		side_d.cmd = command;
		side_d.res = 64'b0;
		side_d.cmp = 1'b0;
		side_d.st  = falu_pkg::ST_OK;
		case (command)
			falu_pkg::CMD_FROM_FRAC: begin
				if (rhs_value[31:0] == 32'b0) side_d.st = falu_pkg::ST_DIVZ;
			end
			falu_pkg::CMD_FROM_INT: side_d.res = {lhs_value[31:0], 32'b0};
			falu_pkg::CMD_ADD: begin
				side_d.res = sum_ab[63:0];
				if (sum_ab[64]) side_d.st = falu_pkg::ST_OVF;
			end
			falu_pkg::CMD_ADD_INT: begin
				side_d.res = sum_ai[63:0];
				if (sum_ai[64]) side_d.st = falu_pkg::ST_OVF;
			end
			falu_pkg::CMD_SUB: begin
				side_d.res = lhs_value - rhs_value;
				if (lhs_value < rhs_value) side_d.st = falu_pkg::ST_UNDER;
			end
			falu_pkg::CMD_SUB_INT: begin
				side_d.res = lhs_value - bint;
				if (lhs_value < bint) side_d.st = falu_pkg::ST_UNDER;
			end
			falu_pkg::CMD_MUL, falu_pkg::CMD_MUL_INT: side_d.res = 64'b0;
			falu_pkg::CMD_DIV: begin
				if (rhs_value == 64'b0) side_d.st = falu_pkg::ST_DIVZ;
			end
			falu_pkg::CMD_DIV_INT: begin
				if (rhs_value[31:0] == 32'b0) side_d.st = falu_pkg::ST_DIVZ;
			end
			falu_pkg::CMD_MIN: side_d.res = (lhs_value < rhs_value) ? lhs_value : rhs_value;
			falu_pkg::CMD_MAX: side_d.res = (lhs_value > rhs_value) ? lhs_value : rhs_value;
			falu_pkg::CMD_GT:     side_d.cmp = lhs_value > rhs_value;
			falu_pkg::CMD_GT_INT: side_d.cmp = lhs_value > bint;
			falu_pkg::CMD_LT:     side_d.cmp = lhs_value < rhs_value;
			falu_pkg::CMD_LE:     side_d.cmp = lhs_value <= rhs_value;
			falu_pkg::CMD_LT_INT: side_d.cmp = lhs_value < bint;
			falu_pkg::CMD_LE_INT: side_d.cmp = lhs_value <= bint;
			falu_pkg::CMD_EQ:     side_d.cmp = lhs_value == rhs_value;
			falu_pkg::CMD_CEIL: begin
				if (lhs_value[63:32] == 32'hFFFF_FFFF && frac_nz) begin
					side_d.st = falu_pkg::ST_OVF;
				end else begin
					side_d.res = {32'b0, lhs_value[63:32] + {31'b0, frac_nz}};
				end
			end
			falu_pkg::CMD_FLOOR: side_d.res = {32'b0, lhs_value[63:32]};
			falu_pkg::CMD_ROUND: begin
				side_d.res = {32'b0, sum_rd[63:32]};
				if (sum_rd[64]) side_d.st = falu_pkg::ST_OVF;
			end
			default: side_d.cmd = command;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_d;
			div_s1  <= div_d;
			prod_s1 <= prod_d;
		end
	end

endmodule

### rtl/falu_mul_sum.sv
`timescale 1ns / 1ps

module falu_mul_sum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_s1,
	input  falu_pkg::side_t  side_s1,
	input  falu_pkg::div_t   div_s1,
	input  falu_pkg::prod_t  prod_s1,
	output logic             vld_s2,
	output falu_pkg::side_t  side_s2,
	output falu_pkg::div_t   div_s2
);

	logic [65:0]     sum;
	logic            is_mul;
	falu_pkg::side_t side_d;

	assign sum = {2'b0, prod_s1.hh[31:0], 32'b0} + {2'b0, prod_s1.hl}
		+ {2'b0, prod_s1.lh} + {34'b0, prod_s1.ll[63:32]};
	assign is_mul = side_s1.cmd == falu_pkg::CMD_MUL || side_s1.cmd == falu_pkg::CMD_MUL_INT;

	always_comb begin
		side_d = side_s1;
		if (is_mul) begin
			side_d.res = sum[63:0];
			side_d.st  = (prod_s1.hh[63:32] != 32'b0 || sum[65:64] != 2'b0)
				? falu_pkg::ST_OVF : falu_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_d;
			div_s2  <= div_s1;
		end
	end

endmodule

### rtl/falu_div_step.sv
`timescale 1ns / 1ps

module falu_div_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_in,
	input  falu_pkg::side_t  side_in,
	input  falu_pkg::div_t   div_in,
	output logic             vld_sn,
	output falu_pkg::side_t  side_sn,
	output falu_pkg::div_t   div_sn
);

	logic [64:0]    trial;
	logic [64:0]    diff;
	logic           ge;
	falu_pkg::div_t div_d;

	assign trial = {div_in.rem, div_in.bits[95]};
	assign diff  = trial - {1'b0, div_in.dvs};
	assign ge    = trial >= {1'b0, div_in.dvs};

	always_comb begin
		div_d.dvs  = div_in.dvs;
		div_d.rem  = ge ? diff[63:0] : trial[63:0];
		div_d.bits = {div_in.bits[94:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (adv) begin
			vld_sn <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sn <= side_in;
			div_sn  <= div_d;
		end
	end

endmodule

### rtl/fixed_point_32_32_alu.sv
`timescale 1ns / 1ps

// Unsigned Q32.32 ALU on a valid/ready request and response channel. Every
// request gives exactly one response, in order. The pipe has 99 register
// stages: one for decode, the simple operations and the four 32x32 partial
// products, one to sum the products, 96 stages of a pipelined restoring
// divider that resolves one quotient bit per stage, and one for the
// round-half-up and the output register. A skid register behind the output
// stage catches a response that the sink does not take, so request ready
// depends only on that register: the whole pipeline holds only while the skid
// register is full. A new request is taken every cycle while it is empty.
// Status reports 1 on wrap, 2 on subtraction underflow and 3 on divide by zero
// (the result is then 0). Unknown commands return all zero fields.
module fixed_point_32_32_alu (
	input  logic          clk,
	input  logic          arst_n,
	falu_req_if.sink      req,
	falu_rsp_if.source    rsp
);

	// Advance the whole pipe unless the skid register holds a response
	logic adv;

	logic            vld_s1;
	falu_pkg::side_t side_s1;
	falu_pkg::div_t  div_s1;
	falu_pkg::prod_t prod_s1;

	logic            vld_s2;
	falu_pkg::side_t side_s2;
	falu_pkg::div_t  div_s2;

	logic            vld_w  [falu_pkg::DivSteps+1];
	falu_pkg::side_t side_w [falu_pkg::DivSteps+1];
	falu_pkg::div_t  div_w  [falu_pkg::DivSteps+1];

	// Final stage: rounding and selection
	logic [95:0] quo;
	logic        rnd_up;
	logic [96:0] quo_rnd;
	logic        is_div;
	logic        vld_s99;
	logic [63:0] res_s99;
	logic        cmp_s99;
	logic [1:0]  st_s99;
	logic [63:0] res_d;
	logic [1:0]  st_d;

	// Skid register for a response the sink did not take
	logic        skid_vld_q;
	logic [63:0] skid_res_q;
	logic        skid_cmp_q;
	logic [1:0]  skid_st_q;

	assign adv       = !skid_vld_q;
	assign req.ready = adv;

	falu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld       (req.valid),
		.command   (req.command),
		.lhs_value (req.lhs_value),
		.rhs_value (req.rhs_value),
		.vld_s1    (vld_s1),
		.side_s1   (side_s1),
		.div_s1    (div_s1),
		.prod_s1   (prod_s1)
	);

	falu_mul_sum u_mul_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.side_s1 (side_s1),
		.div_s1  (div_s1),
		.prod_s1 (prod_s1),
		.vld_s2  (vld_s2),
		.side_s2 (side_s2),
		.div_s2  (div_s2)
	);

	assign vld_w[0]  = vld_s2;
	assign side_w[0] = side_s2;
	assign div_w[0]  = div_s2;

	// One quotient bit per stage, most significant first
	for (genvar i = 0; i < falu_pkg::DivSteps; i++) begin : g_div
		falu_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (vld_w[i]),
			.side_in (side_w[i]),
			.div_in  (div_w[i]),
			.vld_sn  (vld_w[i+1]),
			.side_sn (side_w[i+1]),
			.div_sn  (div_w[i+1])
		);
	end

	assign quo     = div_w[falu_pkg::DivSteps].bits;
	// Round half up: remainder times two against divisor, 65-bit compare
	assign rnd_up  = {div_w[falu_pkg::DivSteps].rem, 1'b0}
		>= {1'b0, div_w[falu_pkg::DivSteps].dvs};
	assign quo_rnd = {1'b0, quo} + {96'b0, rnd_up};
	assign is_div  = (side_w[falu_pkg::DivSteps].cmd == falu_pkg::CMD_FROM_FRAC
		|| side_w[falu_pkg::DivSteps].cmd == falu_pkg::CMD_DIV
		|| side_w[falu_pkg::DivSteps].cmd == falu_pkg::CMD_DIV_INT)
		&& side_w[falu_pkg::DivSteps].st != falu_pkg::ST_DIVZ;

	always_comb begin
		res_d = side_w[falu_pkg::DivSteps].res;
		st_d  = side_w[falu_pkg::DivSteps].st;
		if (is_div) begin
			// Wrap modulo 2^64; any quotient bit above that is an overflow
			res_d = quo_rnd[63:0];
			st_d  = (quo_rnd[96:64] != 33'b0) ? falu_pkg::ST_OVF : falu_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s99 <= 1'b0;
		end else if (adv) begin
			vld_s99 <= vld_w[falu_pkg::DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s99 <= res_d;
			cmp_s99 <= side_w[falu_pkg::DivSteps].cmp;
			st_s99  <= st_d;
		end
	end

	// Fill the skid register when the pipe advances past an untaken response;
	// drain it when the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (rsp.ready) skid_vld_q <= 1'b0;
		end else if (vld_s99 && !rsp.ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_res_q <= res_s99;
			skid_cmp_q <= cmp_s99;
			skid_st_q  <= st_s99;
		end
	end

	assign rsp.valid        = skid_vld_q || vld_s99;
	assign rsp.result_value = skid_vld_q ? skid_res_q : res_s99;
	assign rsp.compare_true = skid_vld_q ? skid_cmp_q : cmp_s99;
	assign rsp.status       = skid_vld_q ? skid_st_q : st_s99;

	// Input side opens exactly when the skid register is empty
	a_ready_follows_skid: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == !skid_vld_q)
		else $error("request ready out of step with skid register");

	// Divide by zero always returns a zero result
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == falu_pkg::ST_DIVZ |-> rsp.result_value == 64'b0)
		else $error("divide by zero with nonzero result");

	// A true comparison never raises a status and never produces a value
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.compare_true |-> rsp.status == falu_pkg::ST_OK
		&& rsp.result_value == 64'b0)
		else $error("comparison response carries status or value");

	// An untaken response stays offered and unchanged
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value)
		&& $stable(rsp.compare_true) && $stable(rsp.status))
		else $error("response changed during output stall");

endmodule
